### hdl/mpsm_pkg.sv
// shared types, constants and helpers for the masked pattern stream matcher
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package mpsm_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 17;
    localparam int LEN_W   = 4;
    localparam int RANGE_W = 16;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;

    localparam int MAX_PATTERN_BYTES_DEF = 8;

    localparam logic [IDX_W-1:0] REG_PATTERN_BYTES    = 3'd0;
    localparam logic [IDX_W-1:0] REG_MASK_BYTES       = 3'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_RANGE_FIRST      = 3'd3;
    localparam logic [IDX_W-1:0] REG_RANGE_LAST       = 3'd4;
    localparam logic [IDX_W-1:0] REG_CASE_INSENSITIVE = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LO_Z = 8'h7A;

    typedef struct packed {
        logic [CFG_W-1:0]   pattern_bytes;
        logic [CFG_W-1:0]   mask_bytes;
        logic [LEN_W-1:0]   pattern_length;
        logic [RANGE_W-1:0] range_first;
        logic [RANGE_W-1:0] range_last;
        logic               case_insensitive;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [POS_W-1:0] pos;
    } stage_ctl_t;

    function automatic logic [BYTE_W-1:0] other_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            r = c - CHAR_UP_A + CHAR_LO_A;
        end
        else if (c >= CHAR_LO_A && c <= CHAR_LO_Z)
        begin
            r = c - CHAR_LO_A + CHAR_UP_A;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/mpsm_if.sv
// valid/ready channel interfaces for the byte stream and the match result
// depends on mpsm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mpsm_in_if;
    import mpsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpsm_out_if;
    logic valid;
    logic ready;
    logic match_found;

    modport source (output valid, output match_found, input ready);
    modport sink   (input valid, input match_found, output ready);
endinterface

`default_nettype wire

### hdl/mpsm_front.sv
// stream front end: byte window, saturating position and input stage register
// depends on mpsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpsm_front #(
    parameter int MAX_PATTERN_BYTES = mpsm_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      advance,
    input  wire logic                                      in_valid,
    input  wire logic [mpsm_pkg::BYTE_W-1:0]               data_byte,
    input  wire logic                                      last_byte,
    output logic      [MAX_PATTERN_BYTES*mpsm_pkg::BYTE_W-1:0] stg_window,
    output mpsm_pkg::stage_ctl_t                           stg_ctl
);
    import mpsm_pkg::*;

    localparam int WIN_W = MAX_PATTERN_BYTES * BYTE_W;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_inc;
    logic             accept;
    logic [WIN_W-1:0] stg_window_reg;
    logic             stg_valid_reg;
    logic             stg_last_reg;
    logic [POS_W-1:0] stg_pos_reg;

    assign accept      = advance & in_valid;
    assign window_next = WIN_W'({window_reg, data_byte});
    assign pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

    // running stream state, cleared after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            window_reg <= last_byte ? '0 : window_next;
            pos_reg    <= last_byte ? '0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_window_reg <= window_next;
            stg_last_reg   <= last_byte;
            stg_pos_reg    <= pos_reg;
        end
    end

    assign stg_window = stg_window_reg;
    assign stg_ctl    = '{valid: stg_valid_reg, last: stg_last_reg, pos: stg_pos_reg};

endmodule

`default_nettype wire

### hdl/mpsm_match.sv
// masked compare of the pattern against the window plus start offset check
// depends on mpsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mpsm_match #(
    parameter int MAX_PATTERN_BYTES = mpsm_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire logic [MAX_PATTERN_BYTES*mpsm_pkg::BYTE_W-1:0] window,
    input  wire logic [mpsm_pkg::POS_W-1:0]                    pos,
    input  mpsm_pkg::cfg_t                                     cfg,
    output logic                                               hit
);
    import mpsm_pkg::*;

    localparam int EXT_W = POS_W + 1;

    logic [LEN_W-1:0]  len_used;
    logic [BYTE_W-1:0] sel_byte [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] pat      [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] msk      [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic [EXT_W-1:0]  pos_end;
    logic [EXT_W-1:0]  len_ext;
    logic [EXT_W-1:0]  start;
    logic              reach;
    logic              in_range;

    always_comb
    begin
        len_used = cfg.pattern_length;
        if (len_used == '0)
        begin
            len_used = LEN_W'(1);
        end
        if (len_used > LEN_W'(MAX_PATTERN_BYTES))
        begin
            len_used = LEN_W'(MAX_PATTERN_BYTES);
        end
    end

    // pattern byte i lines up with window byte len-1-i
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            sel_byte[i] = '0;
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                if (int'(len_used) - 1 - i == j)
                begin
                    sel_byte[i] = window[BYTE_W*j +: BYTE_W];
                end
            end
            pat[i] = cfg.pattern_bytes[BYTE_W*i +: BYTE_W];
            msk[i] = cfg.mask_bytes[BYTE_W*i +: BYTE_W];
            byte_ok[i] = (i >= int'(len_used))
                || ((pat[i] & msk[i]) == (sel_byte[i] & msk[i]))
                || (cfg.case_insensitive
                    && ((other_case(pat[i]) & msk[i]) == (sel_byte[i] & msk[i])));
        end
    end

    assign pos_end  = {1'b0, pos} + EXT_W'(1);
    assign len_ext  = EXT_W'(len_used);
    assign reach    = pos_end >= len_ext;
    assign start    = pos_end - len_ext;
    assign in_range = (start >= EXT_W'(cfg.range_first)) && (start <= EXT_W'(cfg.range_last));
    assign hit      = reach & in_range & (&byte_ok);

endmodule

`default_nettype wire

### hdl/masked_pattern_stream_matcher.sv
// Masked pattern stream matcher, top level.
// Depends on mpsm_pkg, mpsm_if, mpsm_front and mpsm_match.
//
// Usage:
//   stream_in carries one stream byte per word (data_byte) with last_byte
//   marking the final byte of a stream. result_out carries one word per
//   stream, match_found, set if the configured pattern matched under its
//   byte mask at a start offset in [range_first, range_last] and fully
//   inside the stream.
//   The user writes registers through cfg_we / cfg_index / cfg_data only
//   while idle (not enforced); indexes beyond case_insensitive are ignored.
// Timing:
//   One byte is taken every cycle while ready is high. After the last byte
//   is accepted, the result passes through the input register, window
//   compare and result register before the result word is valid.
// Reset and stall:
//   Reset clears the stream state and restores register defaults. When the
//   receiver holds ready low with a result pending, bytes keep flowing until
//   the next last byte reaches the compare stage; ready then drops until
//   the pending result is taken.
`timescale 1ns / 1ps
`default_nettype none

module masked_pattern_stream_matcher #(
    parameter int MAX_PATTERN_BYTES = mpsm_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mpsm_in_if.sink                          stream_in,
    mpsm_out_if.source                       result_out,
    input  wire logic                        cfg_we,
    input  wire logic [mpsm_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [mpsm_pkg::CFG_W-1:0]  cfg_data
);
    import mpsm_pkg::*;

    localparam int WIN_W = MAX_PATTERN_BYTES * BYTE_W;

    cfg_t             cfg_reg;
    logic [WIN_W-1:0] stg_window;
    stage_ctl_t       stg_ctl;
    logic             hit;
    logic             advance;
    logic             found_reg;
    logic             out_valid_reg;
    logic             out_match_reg;
    logic             emit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes    <= '0;
            cfg_reg.mask_bytes       <= '1;
            cfg_reg.pattern_length   <= LEN_W'(1);
            cfg_reg.range_first      <= '0;
            cfg_reg.range_last       <= '0;
            cfg_reg.case_insensitive <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:    cfg_reg.pattern_bytes    <= cfg_data;
                REG_MASK_BYTES:       cfg_reg.mask_bytes       <= cfg_data;
                REG_PATTERN_LENGTH:   cfg_reg.pattern_length   <= cfg_data[LEN_W-1:0];
                REG_RANGE_FIRST:      cfg_reg.range_first      <= cfg_data[RANGE_W-1:0];
                REG_RANGE_LAST:       cfg_reg.range_last       <= cfg_data[RANGE_W-1:0];
                REG_CASE_INSENSITIVE: cfg_reg.case_insensitive <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    mpsm_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (stream_in.valid),
        .data_byte  (stream_in.data_byte),
        .last_byte  (stream_in.last_byte),
        .stg_window (stg_window),
        .stg_ctl    (stg_ctl)
    );

    mpsm_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .window (stg_window),
        .pos    (stg_ctl.pos),
        .cfg    (cfg_reg),
        .hit    (hit)
    );

    // compare stage holds only when a last word meets an untaken result
    assign advance = !(stg_ctl.valid && stg_ctl.last && out_valid_reg && !result_out.ready);
    assign emit    = stg_ctl.valid && stg_ctl.last && advance;

    assign stream_in.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (stg_ctl.valid && advance)
        begin
            found_reg <= stg_ctl.last ? 1'b0 : (found_reg | hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_match_reg <= found_reg | hit;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.match_found = out_match_reg;

endmodule

`default_nettype wire
